// ===== design/rbnp_pkg.sv =====
// ----------------------------------------------------------------------------
// rbnp_pkg
// Types, constants and helpers shared by the nearest box pick unit.
// ----------------------------------------------------------------------------
package rbnp_pkg;

  localparam int BOX_SLOTS = 64;
  localparam int SLOT_W    = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;
  localparam int CNT_W     = 7;
  localparam int EPS_W     = 16;
  localparam int CFG_W     = 16;
  localparam int DIV_STEPS = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    CFG_BOX_COUNT = 1'b0,
    CFG_PAR_EPS   = 1'b1
  } cfg_e;

  typedef struct packed {
    logic              operation;
    logic [5:0]        box_slot;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic signed [31:0] vec_b_z;
  } in_t;

  typedef struct packed {
    logic       hit_found;
    logic [5:0] hit_index;
  } out_t;

  typedef struct packed {
    logic [2:0][31:0] ctr;
    logic [2:0][31:0] half;
  } box_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic [SLOT_W-1:0] slot;
  } tag_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [31:0] rem;
    logic [31:0] quo;
  } lane_t;

  typedef struct packed {
    logic        par;
    logic        ok;
    logic [31:0] dmag;
    lane_t       lo;
    lane_t       hi;
  } axis_t;

  typedef struct packed {
    tag_t            tag;
    axis_t [2:0]     ax;
  } cell_t;

  function automatic lane_t div_step(lane_t l, logic [31:0] d);
    lane_t       r;
    logic [32:0] t;
    logic        ge;
    t     = {l.rem, l.quo[31]};
    ge    = (t >= {1'b0, d});
    r     = l;
    r.rem = ge ? 32'(t - {1'b0, d}) : t[31:0];
    r.quo = {l.quo[30:0], ge};
    return r;
  endfunction

endpackage

// ===== design/rbnp_ram.sv =====
// ----------------------------------------------------------------------------
// rbnp_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module rbnp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/rbnp_prep.sv =====
// ----------------------------------------------------------------------------
// rbnp_prep
// Slab bounds, offsets and divider operands for one box a cycle.
// ----------------------------------------------------------------------------
module rbnp_prep (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rbnp_pkg::tag_t          tag_i,
  input  rbnp_pkg::box_t          box_i,
  input  logic [2:0][31:0]        org_i,
  input  logic [2:0][31:0]        dir_i,
  input  logic [rbnp_pkg::EPS_W-1:0] eps_i,
  output rbnp_pkg::cell_t         cell_o
);
  import rbnp_pkg::*;

  tag_t             tag1_q, tag2_q;
  logic [2:0][33:0] lo1_q, hi1_q;
  logic [2:0]       par1_q, par2_q;
  logic [2:0][31:0] dm1_q, dm2_q;
  logic [2:0][34:0] nlo2_q, nhi2_q;
  logic [2:0]       ok2_q;
  tag_t             tag3_q;
  axis_t [2:0]      ax3_q;

  logic [2:0][33:0] lo1_d, hi1_d;
  logic [2:0]       par1_d;
  logic [2:0][31:0] dm1_d;
  logic [2:0][34:0] nlo2_d, nhi2_d;
  logic [2:0]       ok2_d;
  cell_t            cell_d;

  function automatic lane_t lane_init(logic [34:0] n, logic dneg, logic [31:0] dm);
    lane_t       l;
    logic [34:0] mag;
    mag   = n[34] ? 35'(35'd0 - n) : n;
    l.neg = n[34] ^ dneg;
    l.ovf = (32'(mag[34:16]) >= dm);
    l.rem = 32'(mag[34:16]);
    l.quo = {mag[15:0], 16'd0};
    return l;
  endfunction

  always_comb begin
    logic [34:0] o35;
    cell_d.tag = tag2_q;
    for (int k = 0; k < 3; k++) begin
      lo1_d[k]  = {{2{box_i.ctr[k][31]}}, box_i.ctr[k]}
                - {{2{box_i.half[k][31]}}, box_i.half[k]};
      hi1_d[k]  = {{2{box_i.ctr[k][31]}}, box_i.ctr[k]}
                + {{2{box_i.half[k][31]}}, box_i.half[k]};
      dm1_d[k]  = dir_i[k][31] ? 32'(32'd0 - dir_i[k]) : dir_i[k];
      par1_d[k] = (dm1_d[k] == 32'd0) || (dm1_d[k] < {16'd0, eps_i});
      o35       = {{3{org_i[k][31]}}, org_i[k]};
      nlo2_d[k] = {lo1_q[k][33], lo1_q[k]} - o35;
      nhi2_d[k] = {hi1_q[k][33], hi1_q[k]} - o35;
      ok2_d[k]  = !(($signed(o35) < $signed({lo1_q[k][33], lo1_q[k]}))
                 || ($signed(o35) > $signed({hi1_q[k][33], hi1_q[k]})));
      cell_d.ax[k].par  = par2_q[k];
      cell_d.ax[k].ok   = ok2_q[k];
      cell_d.ax[k].dmag = dm2_q[k];
      cell_d.ax[k].lo   = lane_init(nlo2_q[k], dir_i[k][31], dm2_q[k]);
      cell_d.ax[k].hi   = lane_init(nhi2_q[k], dir_i[k][31], dm2_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= cell_d.tag;
    end
  end

  always_ff @(posedge clk_i) begin
    lo1_q  <= lo1_d;
    hi1_q  <= hi1_d;
    par1_q <= par1_d;
    dm1_q  <= dm1_d;
    par2_q <= par1_q;
    dm2_q  <= dm1_q;
    nlo2_q <= nlo2_d;
    nhi2_q <= nhi2_d;
    ok2_q  <= ok2_d;
    ax3_q  <= cell_d.ax;
  end

  assign cell_o = {tag3_q, ax3_q};

endmodule

// ===== design/rbnp_div_cell.sv =====
// ----------------------------------------------------------------------------
// rbnp_div_cell
// One restoring division step for all six slab distances of a box.
// ----------------------------------------------------------------------------
module rbnp_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rbnp_pkg::cell_t cell_i,
  output rbnp_pkg::cell_t cell_o
);
  import rbnp_pkg::*;

  cell_t       cell_d;
  tag_t        tag_q;
  axis_t [2:0] ax_q;

  always_comb begin
    cell_d = cell_i;
    for (int k = 0; k < 3; k++) begin
      cell_d.ax[k].lo = div_step(cell_i.ax[k].lo, cell_i.ax[k].dmag);
      cell_d.ax[k].hi = div_step(cell_i.ax[k].hi, cell_i.ax[k].dmag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= cell_d.tag;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= cell_d.ax;
  end

  assign cell_o = {tag_q, ax_q};

endmodule

// ===== design/rbnp_pick.sv =====
// ----------------------------------------------------------------------------
// rbnp_pick
// Saturate slab distances, intersect the slabs and keep the nearest hit.
// ----------------------------------------------------------------------------
module rbnp_pick (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rbnp_pkg::cell_t cell_i,
  output logic            done_o,
  output rbnp_pkg::out_t  res_o
);
  import rbnp_pkg::*;

  localparam logic [31:0] TMAX = 32'h7fff_ffff;
  localparam logic [31:0] TMIN = 32'h8000_0000;

  function automatic logic [31:0] sat(lane_t l);
    logic [31:0] v;
    if (l.ovf) begin
      v = l.neg ? TMIN : TMAX;
    end else if (!l.neg) begin
      v = l.quo[31] ? TMAX : l.quo;
    end else begin
      v = (l.quo > TMIN) ? TMIN : 32'(32'd0 - l.quo);
    end
    return v;
  endfunction

  tag_t             taga_q, tagb_q, tagc_q;
  logic [2:0][31:0] t1a_q, t2a_q, tnb_q, tfb_q;
  logic [2:0]       para_q, oka_q, okb_q;
  logic [31:0]      tminc_q;
  logic             hitc_q;
  logic             found_q;
  logic [SLOT_W-1:0] best_q;
  logic [31:0]      bestt_q;
  logic             done_q;
  out_t             res_q;

  logic [2:0][31:0] t1a_d, t2a_d, tnb_d, tfb_d;
  logic [2:0]       okb_d;
  logic [31:0]      tmin_d, tmax_d;
  logic             hit_d, upd;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t1a_d[k] = sat(cell_i.ax[k].lo);
      t2a_d[k] = sat(cell_i.ax[k].hi);
      if (para_q[k]) begin
        tnb_d[k] = TMIN;
        tfb_d[k] = TMAX;
      end else if ($signed(t1a_q[k]) > $signed(t2a_q[k])) begin
        tnb_d[k] = t2a_q[k];
        tfb_d[k] = t1a_q[k];
      end else begin
        tnb_d[k] = t1a_q[k];
        tfb_d[k] = t2a_q[k];
      end
      okb_d[k] = !para_q[k] || oka_q[k];
    end
    tmin_d = TMIN;
    tmax_d = TMAX;
    for (int k = 0; k < 3; k++) begin
      if ($signed(tnb_q[k]) > $signed(tmin_d)) tmin_d = tnb_q[k];
      if ($signed(tfb_q[k]) < $signed(tmax_d)) tmax_d = tfb_q[k];
    end
    hit_d = tagb_q.vld && (&okb_q) && ($signed(tmin_d) <= $signed(tmax_d))
          && !tmin_d[31];
    upd   = hitc_q && (!found_q || ($signed(tminc_q) < $signed(bestt_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taga_q  <= '0;
      tagb_q  <= '0;
      tagc_q  <= '0;
      hitc_q  <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      taga_q <= cell_i.tag;
      tagb_q <= taga_q;
      tagc_q <= tagb_q;
      hitc_q <= hit_d;
      done_q <= tagc_q.last;
      if (tagc_q.last) begin
        found_q <= 1'b0;
      end else if (upd) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t1a_q   <= t1a_d;
    t2a_q   <= t2a_d;
    para_q  <= {cell_i.ax[2].par, cell_i.ax[1].par, cell_i.ax[0].par};
    oka_q   <= {cell_i.ax[2].ok, cell_i.ax[1].ok, cell_i.ax[0].ok};
    tnb_q   <= tnb_d;
    tfb_q   <= tfb_d;
    okb_q   <= okb_d;
    tminc_q <= tmin_d;
    if (upd) begin
      best_q  <= tagc_q.slot;
      bestt_q <= tminc_q;
    end
    if (tagc_q.last) begin
      res_q.hit_found <= upd || found_q;
      res_q.hit_index <= upd ? 6'(tagc_q.slot)
                       : (found_q ? 6'(best_q) : 6'd0);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/ray_box_nearest_pick_unit.sv =====
// ----------------------------------------------------------------------------
// ray_box_nearest_pick_unit
// Nearest ray pick among stored axis aligned boxes by slab test.
// Query: min(box_count, BOX_SLOTS) boxes, at least one slot, are streamed one a
// cycle through 32 division cells to a valid result.
// One item in flight; the next is taken once the result has transferred.
// Reset clears control and the box count and sets eps to 1; the box store is not cleared.
// ----------------------------------------------------------------------------
module ray_box_nearest_pick_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rbnp_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rbnp_pkg::out_t               out_data_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [rbnp_pkg::CFG_W-1:0]   cfg_data_i
);
  import rbnp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_cfg_q;
  logic [EPS_W-1:0]  eps_q;
  logic [SLOT_W-1:0] cnt_q, cnt_d, lim_q;
  logic              empty_q;
  logic [2:0][31:0]  org_q, dir_q;
  tag_t              tag_d, tag_q;
  out_t              out_q;
  logic              acc, wr_en, done;
  int unsigned       nn;
  box_t              wbox, rbox;
  out_t              res;
  cell_t             chain [DIV_STEPS+1];

  assign acc   = in_valid_i && !in_stall_o;
  assign wr_en = acc && (in_data_i.operation == OP_WRITE)
               && (32'(in_data_i.box_slot) < 32'(BOX_SLOTS));
  assign nn    = (32'(cnt_cfg_q) > 32'(BOX_SLOTS)) ? 32'(BOX_SLOTS) : 32'(cnt_cfg_q);

  assign wbox.ctr  = {in_data_i.vec_a_z, in_data_i.vec_a_y, in_data_i.vec_a_x};
  assign wbox.half = {in_data_i.vec_b_z, in_data_i.vec_b_y, in_data_i.vec_b_x};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    tag_d     = '0;
    tag_d.slot = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (acc && (in_data_i.operation == OP_QUERY)) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        tag_d.vld  = !empty_q;
        tag_d.last = empty_q || (cnt_q == lim_q);
        cnt_d      = cnt_q + 1'b1;
        if (tag_d.last) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      tag_q     <= '0;
      cnt_cfg_q <= '0;
      eps_q     <= EPS_W'(1);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tag_q   <= tag_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_BOX_COUNT: cnt_cfg_q <= cfg_data_i[CNT_W-1:0];
          CFG_PAR_EPS:   eps_q     <= cfg_data_i[EPS_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (in_data_i.operation == OP_QUERY)) begin
      org_q   <= wbox.ctr;
      dir_q   <= wbox.half;
      lim_q   <= SLOT_W'(nn - 1);
      empty_q <= (nn == 0);
    end
    if (done) out_q <= res;
  end

  rbnp_ram #(
    .WIDTH($bits(box_t)),
    .DEPTH(BOX_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(SLOT_W'(in_data_i.box_slot)),
    .wdata_i(wbox),
    .raddr_i(cnt_q),
    .rdata_o(rbox)
  );

  rbnp_prep u_prep (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tag_i (tag_q),
    .box_i (rbox),
    .org_i (org_q),
    .dir_i (dir_q),
    .eps_i (eps_q),
    .cell_o(chain[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    rbnp_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(chain[g]),
      .cell_o(chain[g+1])
    );
  end

  rbnp_pick u_pick (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cell_i(chain[DIV_STEPS]),
    .done_o(done),
    .res_o (res)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;

endmodule

// ===== design/rbnp_chk.sv =====
// ----------------------------------------------------------------------------
// rbnp_chk
// Port level checks for the nearest box pick unit.
// ----------------------------------------------------------------------------
module rbnp_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input rbnp_pkg::in_t              in_data_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input rbnp_pkg::out_t             out_data_o
);
  import rbnp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit_found |-> out_data_o.hit_index == 6'd0)
    else $error("miss with nonzero index");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_query_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.operation == OP_QUERY)
    |=> !out_valid_o ##1 !out_valid_o)
    else $error("result too early after query");

endmodule

bind ray_box_nearest_pick_unit rbnp_chk u_chk (.*);
